[rtl/hpbt_pkg.sv]
// Shared types, codes and helpers for the homogeneous point and box transform.
// Used by every module in rtl/; depends on nothing.
package hpbt_pkg;

    localparam int NUM_REGS   = 8;
    localparam int IDX_W      = 3;
    localparam int DIV_STEPS  = 4;   // quotient bits per divider stage
    localparam int DIV_STAGES = 8;   // 32 quotient bits in all

    localparam logic [1:0] REQ_POINT = 2'd0;
    localparam logic [1:0] REQ_DIR   = 2'd1;
    localparam logic [1:0] REQ_BOX   = 2'd2;

    localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic signed [31:0] bz;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] rx0;
        logic signed [31:0] ry0;
        logic signed [31:0] rz0;
        logic signed [31:0] rx1;
        logic signed [31:0] ry1;
        logic signed [31:0] rz1;
        logic               w_zero;
    } t_out_word;

    typedef struct packed {
        logic       valid;
        logic [1:0] req_type;
    } t_meta;

    // Reset value of each coefficient register: identity matrix.
    function automatic logic [63:0] coef_reset(input int idx);
        logic [63:0] v;
        v = 64'd0;
        if (idx == 0 || idx == 5) begin
            v = 64'h0001_0000_0000_0000;
        end else if (idx == 2 || idx == 7) begin
            v = 64'h0000_0000_0001_0000;
        end
        return v;
    endfunction

    // Even column in the high half, odd column in the low half.
    function automatic logic signed [31:0] coef_entry(input logic [63:0] reg_v,
                                                      input logic odd);
        return odd ? $signed(reg_v[31:0]) : $signed(reg_v[63:32]);
    endfunction

endpackage

[rtl/hpbt_mul.sv]
// Product stage: every matrix entry of the left 4x3 part times both corners.
// Depends on hpbt_pkg.
module hpbt_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hpbt_pkg::t_meta    i_meta,
    input  hpbt_pkg::t_in_word i_word,
    input  logic [63:0]        i_coef [8],
    output hpbt_pkg::t_meta    o_meta,
    output logic signed [63:0] o_pa [4][3],
    output logic signed [63:0] o_pb [4][3]
);
    import hpbt_pkg::*;

    logic signed [31:0] a_v [3];
    logic signed [31:0] b_v [3];
    t_meta              r_meta;
    logic signed [63:0] r_pa [4][3];
    logic signed [63:0] r_pb [4][3];

    assign a_v[0] = i_word.ax;
    assign a_v[1] = i_word.ay;
    assign a_v[2] = i_word.az;
    assign b_v[0] = i_word.bx;
    assign b_v[1] = i_word.by;
    assign b_v[2] = i_word.bz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meta.valid <= 1'b0;
        end else begin
            r_meta <= i_meta;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 3; c++) begin
                r_pa[r][c] <= coef_entry(i_coef[r*2 + c/2], c[0]) * a_v[c];
                r_pb[r][c] <= coef_entry(i_coef[r*2 + c/2], c[0]) * b_v[c];
            end
        end
    end

    assign o_meta = r_meta;
    assign o_pa   = r_pa;
    assign o_pb   = r_pb;

endmodule

[rtl/hpbt_rsum.sv]
// Row sums for all eight corners: pair sums, then final add, round, saturate.
// Depends on hpbt_pkg.
module hpbt_rsum (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hpbt_pkg::t_meta    i_meta,
    input  logic signed [63:0] i_pa [4][3],
    input  logic signed [63:0] i_pb [4][3],
    input  logic [63:0]        i_coef [8],
    output hpbt_pkg::t_meta    o_meta,
    output logic signed [31:0] o_val [8][4]
);
    import hpbt_pkg::*;

    t_meta              r_meta_a;
    t_meta              r_meta_b;
    logic signed [67:0] r_xy [4][4];   // x/y part, index {y sel, x sel}
    logic signed [67:0] r_zt [4][2];   // z part plus translation and half LSB
    logic signed [31:0] r_val [8][4];
    logic               with_t;

    assign with_t = (i_meta.req_type != REQ_DIR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meta_a.valid <= 1'b0;
            r_meta_b.valid <= 1'b0;
        end else begin
            r_meta_a <= i_meta;
            r_meta_b <= r_meta_a;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 4; r++) begin
            for (int j = 0; j < 4; j++) begin
                r_xy[r][j] <= 68'(j[0] ? i_pb[r][0] : i_pa[r][0])
                            + 68'(j[1] ? i_pb[r][1] : i_pa[r][1]);
            end
            for (int j = 0; j < 2; j++) begin
                r_zt[r][j] <= 68'(j[0] ? i_pb[r][2] : i_pa[r][2])
                            + (with_t ? 68'($signed({coef_entry(i_coef[r*2+1], 1'b1),
                                                      16'h0000})) : 68'sd0)
                            + 68'sd32768;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [67:0] tot;
        logic signed [67:0] sh;
        for (int k = 0; k < 8; k++) begin
            for (int r = 0; r < 4; r++) begin
                tot = r_xy[r][k[1:0]] + r_zt[r][k[2]];
                sh  = tot >>> 16;
                if (sh[67:31] != {37{sh[67]}}) begin
                    r_val[k][r] <= sh[67] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                end else begin
                    r_val[k][r] <= sh[31:0];
                end
            end
        end
    end

    assign o_meta = r_meta_b;
    assign o_val  = r_val;

endmodule

[rtl/hpbt_div.sv]
// Pipelined divide by w for 8 corners x 3 axes, with skip and saturation.
// Depends on hpbt_pkg.
module hpbt_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hpbt_pkg::t_meta    i_meta,
    input  logic signed [31:0] i_val [8][4],
    output hpbt_pkg::t_meta    o_meta,
    output logic signed [31:0] o_res [8][3],
    output logic [7:0]         o_wz
);
    import hpbt_pkg::*;

    typedef struct packed {
        logic [31:0]        rem;
        logic [31:0]        nlo;
        logic [31:0]        quo;
        logic [31:0]        den;
        logic               ovf;
        logic               neg;
        logic               skip;
        logic signed [31:0] x;
    } t_dlane;

    t_meta              r_meta [DIV_STAGES+2];
    logic [7:0]         r_wz   [DIV_STAGES+2];
    t_dlane             r_ln   [DIV_STAGES+1][8][3];
    logic signed [31:0] r_res  [8][3];

    function automatic t_dlane div_step(input t_dlane l);
        t_dlane     o;
        logic [32:0] rem33;
        o = l;
        for (int s = 0; s < DIV_STEPS; s++) begin
            rem33 = {o.rem, o.nlo[31]};
            o.nlo = {o.nlo[30:0], 1'b0};
            if (rem33 >= {1'b0, o.den}) begin
                rem33 = rem33 - {1'b0, o.den};
                o.quo = {o.quo[30:0], 1'b1};
            end else begin
                o.quo = {o.quo[30:0], 1'b0};
            end
            o.rem = rem33[31:0];
        end
        return o;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DIV_STAGES + 2; s++) begin
                r_meta[s].valid <= 1'b0;
            end
        end else begin
            r_meta[0] <= i_meta;
            for (int s = 1; s < DIV_STAGES + 2; s++) begin
                r_meta[s] <= r_meta[s-1];
            end
        end
    end

    // prep: magnitudes, rounding term, overflow check; then the divider stages
    always_ff @(posedge i_clk) begin
        logic signed [31:0] w;
        logic [31:0]        mx;
        logic [31:0]        d;
        logic [48:0]        n;
        for (int k = 0; k < 8; k++) begin
            w = i_val[k][3];
            d = w[31] ? (~w + 32'd1) : w;
            r_wz[0][k] <= (w == 32'sd0);
            for (int i = 0; i < 3; i++) begin
                mx = i_val[k][i][31] ? (~i_val[k][i] + 32'd1) : i_val[k][i];
                n  = {1'b0, mx, 16'h0000} + {17'd0, 1'b0, d[31:1]};
                r_ln[0][k][i].rem  <= {15'd0, n[48:32]};
                r_ln[0][k][i].nlo  <= n[31:0];
                r_ln[0][k][i].quo  <= 32'd0;
                r_ln[0][k][i].den  <= d;
                r_ln[0][k][i].ovf  <= ({15'd0, n} >= {d, 32'd0});
                r_ln[0][k][i].neg  <= i_val[k][i][31] ^ w[31];
                r_ln[0][k][i].skip <= (w == ONE_Q16) || (w == 32'sd0)
                                    || (i_meta.req_type == REQ_DIR);
                r_ln[0][k][i].x    <= i_val[k][i];
            end
        end
        for (int s = 0; s < DIV_STAGES; s++) begin
            r_wz[s+1] <= r_wz[s];
            for (int k = 0; k < 8; k++) begin
                for (int i = 0; i < 3; i++) begin
                    r_ln[s+1][k][i] <= div_step(r_ln[s][k][i]);
                end
            end
        end
        r_wz[DIV_STAGES+1] <= r_wz[DIV_STAGES];
    end

    // sign and saturation
    always_ff @(posedge i_clk) begin
        t_dlane      l;
        logic [32:0] mag;
        for (int k = 0; k < 8; k++) begin
            for (int i = 0; i < 3; i++) begin
                l   = r_ln[DIV_STAGES][k][i];
                mag = l.ovf ? 33'h1_0000_0000 : {1'b0, l.quo};
                if (l.skip) begin
                    r_res[k][i] <= l.x;
                end else if (l.neg) begin
                    r_res[k][i] <= (mag > 33'h0_8000_0000) ? 32'sh8000_0000
                                                            : $signed(~mag[31:0] + 32'd1);
                end else begin
                    r_res[k][i] <= (mag > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF
                                                            : $signed(mag[31:0]);
                end
            end
        end
    end

    assign o_meta = r_meta[DIV_STAGES+1];
    assign o_res  = r_res;
    assign o_wz   = r_wz[DIV_STAGES+1];

endmodule

[rtl/hpbt_mm.sv]
// Per-axis min/max over the eight corners and result word formatting.
// Depends on hpbt_pkg.
module hpbt_mm (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hpbt_pkg::t_meta     i_meta,
    input  logic signed [31:0]  i_res [8][3],
    input  logic [7:0]          i_wz,
    output logic                o_valid,
    output hpbt_pkg::t_out_word o_word
);
    import hpbt_pkg::*;

    t_meta              r_meta;
    logic signed [31:0] r_lo [2][3];
    logic signed [31:0] r_hi [2][3];
    logic signed [31:0] r_p0 [3];
    logic               r_wz0;
    logic               r_wzany;
    logic               r_valid;
    t_out_word          r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meta.valid <= 1'b0;
            r_valid      <= 1'b0;
        end else begin
            r_meta  <= i_meta;
            r_valid <= r_meta.valid;
        end
    end

    // two compare levels: 8 corners down to 2 per axis
    always_ff @(posedge i_clk) begin
        logic signed [31:0] l1 [2];
        logic signed [31:0] h1 [2];
        for (int i = 0; i < 3; i++) begin
            for (int g = 0; g < 2; g++) begin
                for (int p = 0; p < 2; p++) begin
                    l1[p] = (i_res[g*4+p*2][i] < i_res[g*4+p*2+1][i])
                          ? i_res[g*4+p*2][i] : i_res[g*4+p*2+1][i];
                    h1[p] = (i_res[g*4+p*2][i] > i_res[g*4+p*2+1][i])
                          ? i_res[g*4+p*2][i] : i_res[g*4+p*2+1][i];
                end
                r_lo[g][i] <= (l1[0] < l1[1]) ? l1[0] : l1[1];
                r_hi[g][i] <= (h1[0] > h1[1]) ? h1[0] : h1[1];
            end
            r_p0[i] <= i_res[0][i];
        end
        r_wz0   <= i_wz[0];
        r_wzany <= |i_wz;
    end

    always_ff @(posedge i_clk) begin
        logic signed [31:0] lo [3];
        logic signed [31:0] hi [3];
        t_out_word          n_word;
        for (int i = 0; i < 3; i++) begin
            lo[i] = (r_lo[0][i] < r_lo[1][i]) ? r_lo[0][i] : r_lo[1][i];
            hi[i] = (r_hi[0][i] > r_hi[1][i]) ? r_hi[0][i] : r_hi[1][i];
        end
        n_word = '0;
        if (r_meta.req_type == REQ_POINT || r_meta.req_type == REQ_DIR) begin
            n_word.rx0    = r_p0[0];
            n_word.ry0    = r_p0[1];
            n_word.rz0    = r_p0[2];
            n_word.w_zero = (r_meta.req_type == REQ_POINT) && r_wz0;
        end else if (r_meta.req_type == REQ_BOX) begin
            n_word.rx0    = lo[0];
            n_word.ry0    = lo[1];
            n_word.rz0    = lo[2];
            n_word.rx1    = hi[0];
            n_word.ry1    = hi[1];
            n_word.rz1    = hi[2];
            n_word.w_zero = r_wzany;
        end
        r_word <= n_word;
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

[rtl/homogeneous_point_box_transform.sv]
// Top level: Q16.16 4x4 homogeneous transform of points, vectors and boxes.
// Depends on hpbt_pkg, hpbt_mul, hpbt_rsum, hpbt_div, hpbt_mm.
//
// Usage
//  - Command channel: a word (request type plus two corners) is taken on
//    each rising edge with start high and busy low. busy never rises, so a
//    new word may be issued every cycle.
//  - Result channel: o_res_valid strobes for exactly one cycle with the
//    result word on o_res, after the command has run through every stage.
//    One result per command, in command order. The receiver cannot stall;
//    nothing here holds results back.
//  - Config channel: i_cfg_valid / o_cfg_ready (always ready), i_cfg_index
//    selects one of eight 64-bit coefficient registers. Write only when no
//    command is in flight.
//  - Throughput: one word per cycle. Stages in order: products (1), row
//    sums (2), divide prep (1), eight 4-bit radix-2 divider stages (8),
//    sign/saturate (1), min/max tree (2).
//  - Reset (synchronous, active low) loads the identity matrix and clears
//    all valid bits; the pipeline payload is not cleared.
module homogeneous_point_box_transform (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  hpbt_pkg::t_in_word  i_in,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [63:0]         i_cfg_data,
    output logic                o_res_valid,
    output hpbt_pkg::t_out_word o_res
);
    import hpbt_pkg::*;

    logic [63:0]        r_coef [NUM_REGS];
    t_meta              in_meta;
    t_meta              mul_meta;
    t_meta              rs_meta;
    t_meta              dv_meta;
    logic signed [63:0] pa [4][3];
    logic signed [63:0] pb [4][3];
    logic signed [31:0] rs_val [8][4];
    logic signed [31:0] dv_res [8][3];
    logic [7:0]         dv_wz;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // coefficient registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_coef[i] <= coef_reset(i);
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_coef[i_cfg_index[IDX_W-1:0]] <= i_cfg_data;
        end
    end

    assign in_meta.valid    = start && !busy;
    assign in_meta.req_type = i_in.req_type;

    hpbt_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_meta  (in_meta),
        .i_word  (i_in),
        .i_coef  (r_coef),
        .o_meta  (mul_meta),
        .o_pa    (pa),
        .o_pb    (pb)
    );

    hpbt_rsum u_rsum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_meta  (mul_meta),
        .i_pa    (pa),
        .i_pb    (pb),
        .i_coef  (r_coef),
        .o_meta  (rs_meta),
        .o_val   (rs_val)
    );

    hpbt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_meta  (rs_meta),
        .i_val   (rs_val),
        .o_meta  (dv_meta),
        .o_res   (dv_res),
        .o_wz    (dv_wz)
    );

    hpbt_mm u_mm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_meta  (dv_meta),
        .i_res   (dv_res),
        .i_wz    (dv_wz),
        .o_valid (o_res_valid),
        .o_word  (o_res)
    );

endmodule

[tb/sv/homogeneous_point_box_transform_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for homogeneous_point_box_transform: Q16.16 matrix
// transform of points, direction vectors and boxes, checked against a local predictor.
// Depends on hpbt_pkg and the RTL top level only.
module homogeneous_point_box_transform_test;
    import hpbt_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;      // spare request code, all-zero result
    localparam logic [31:0] Q_ONE = 32'h0001_0000;
    localparam logic [31:0] Q_NEG_ONE = 32'hFFFF_0000;
    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;
    localparam int SETTLE_CYCLES = 25;             // pipeline is 15 deep

    typedef logic [2:0][31:0] t_vec3;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_in_word    i_in;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [63:0] i_cfg_data;
    logic        o_res_valid;
    t_out_word   o_res;

    homogeneous_point_box_transform dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_in        (i_in),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Local copy of the coefficient bank, updated as writes are accepted.
    logic [63:0] coef_bank [NUM_REGS];

    t_in_word    cmd_q [$];       // words waiting to be issued
    t_out_word   result_q [$];    // predicted results, oldest first
    logic [66:0] coef_wr_q [$];   // {index, data} writes waiting
    int          gap_left;
    bit          gaps_on;
    int          fail_count;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic signed [31:0] coef_at(input int r, input int c);
        logic [63:0] w;
        w = coef_bank[r * 2 + c / 2];
        return (c % 2) ? $signed(w[31:0]) : $signed(w[63:32]);
    endfunction

    function automatic logic [31:0] clamp32(input logic signed [127:0] v);
        if (v > 128'sd2147483647) return Q_MAX;
        if (v < -128'sd2147483648) return Q_MIN;
        return v[31:0];
    endfunction

    // Exact row sum, round half up to Q16.16, then clamp.
    function automatic logic [31:0] row_dot(input int r, input t_vec3 v, input bit with_t);
        logic signed [127:0] acc;
        acc = 128'sd32768;
        for (int c = 0; c < 3; c++)
            acc += 128'(coef_at(r, c)) * 128'($signed(v[c]));
        if (with_t)
            acc += 128'(coef_at(r, 3)) <<< 16;
        acc = acc >>> 16;
        return clamp32(acc);
    endfunction

    // Magnitude divide rounded to nearest, ties away from zero.
    function automatic logic [31:0] q16_divide(input logic [31:0] num, input logic [31:0] den);
        logic signed [63:0] sn, sd, sq;
        logic [63:0] n, d, q;
        sn = 64'($signed(num));
        sd = 64'($signed(den));
        n = (sn < 0 ? -sn : sn) << 16;
        d = (sd < 0 ? -sd : sd);
        q = (n + d / 2) / d;
        sq = ((sn < 0) != (sd < 0)) ? -$signed(q) : $signed(q);
        return clamp32(128'(sq));
    endfunction

    // Returns 1 when w' came out zero (values left undivided).
    function automatic bit point_map(input t_vec3 p, output t_vec3 r);
        logic [31:0] w;
        w = row_dot(3, p, 1'b1);
        for (int i = 0; i < 3; i++)
            r[i] = row_dot(i, p, 1'b1);
        if (w == Q_ONE) return 1'b0;
        if (w == 32'd0) return 1'b1;
        for (int i = 0; i < 3; i++)
            r[i] = q16_divide(r[i], w);
        return 1'b0;
    endfunction

    function automatic t_out_word transform_word(input t_in_word cmd);
        t_out_word res;
        t_vec3 a, b, lo, hi, c, r;
        bit wz;
        a = {cmd.az, cmd.ay, cmd.ax};
        b = {cmd.bz, cmd.by, cmd.bx};
        lo = '0;
        hi = '0;
        wz = 1'b0;
        case (cmd.req_type)
            REQ_POINT: wz = point_map(a, lo);
            REQ_DIR: begin
                for (int i = 0; i < 3; i++)
                    lo[i] = row_dot(i, a, 1'b0);
            end
            REQ_BOX: begin
                for (int k = 0; k < 8; k++) begin
                    for (int i = 0; i < 3; i++)
                        c[i] = ((k >> i) & 1) ? b[i] : a[i];
                    if (point_map(c, r)) wz = 1'b1;
                    for (int i = 0; i < 3; i++) begin
                        if (k == 0 || $signed(r[i]) < $signed(lo[i])) lo[i] = r[i];
                        if (k == 0 || $signed(r[i]) > $signed(hi[i])) hi[i] = r[i];
                    end
                end
            end
            default: ;
        endcase
        res.rx0 = lo[0];
        res.ry0 = lo[1];
        res.rz0 = lo[2];
        res.rx1 = hi[0];
        res.ry1 = hi[1];
        res.rz1 = hi[2];
        res.w_zero = wz;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Command driver: issues queued words, random gaps in between.
    // ------------------------------------------------------------------

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            i_in <= '0;
            gap_left <= 0;
        end else begin
            if (start && !busy)
                result_q.push_back(transform_word(i_in));
            if (start && busy) begin
                // hold the word until taken
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end else if (cmd_q.size() > 0 && coef_wr_q.size() == 0 && !i_cfg_valid) begin
                // words only go out once the coefficient writes have landed
                i_in <= cmd_q.pop_front();
                start <= 1'b1;
                gap_left <= pick_gap();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Coefficient writes, same pattern on their own channel.
    always @(posedge i_clk) begin
        logic [66:0] wr;
        if (!i_rst_n) begin
            i_cfg_valid <= 1'b0;
            i_cfg_index <= '0;
            i_cfg_data <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready)
                coef_bank[i_cfg_index] = i_cfg_data;
            if (i_cfg_valid && !o_cfg_ready) begin
                // hold
            end else if (coef_wr_q.size() > 0) begin
                wr = coef_wr_q.pop_front();
                i_cfg_index <= wr[66:64];
                i_cfg_data <= wr[63:0];
                i_cfg_valid <= 1'b1;
            end else begin
                i_cfg_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every strobed word against the oldest prediction.
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_res_valid) begin
            if (result_q.size() == 0) begin
                $error("result word with nothing expected: %h", o_res);
                fail_count++;
            end else begin
                want = result_q.pop_front();
                check_field("rx0", want.rx0, o_res.rx0);
                check_field("ry0", want.ry0, o_res.ry0);
                check_field("rz0", want.rz0, o_res.rz0);
                check_field("rx1", want.rx1, o_res.rx1);
                check_field("ry1", want.ry1, o_res.ry1);
                check_field("rz1", want.rz1, o_res.rz1);
                check_field("w_zero", 32'(want.w_zero), 32'(o_res.w_zero));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    function automatic logic [31:0] rand_q16(input int range_sel);
        case (range_sel)
            0: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;  // within +-4.0
            1: return $urandom();
            default: begin
                case ($urandom_range(0, 4))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return Q_ONE;
                    3: return Q_NEG_ONE;
                    default: return 32'd0;
                endcase
            end
        endcase
    endfunction

    function automatic logic [31:0] rand_val();
        int r;
        r = $urandom_range(0, 9);
        return rand_q16(r < 6 ? 0 : (r < 9 ? 1 : 2));
    endfunction

    function automatic t_in_word mk_word(input logic [1:0] kind, input logic [31:0] ax,
                                         input logic [31:0] ay, input logic [31:0] az,
                                         input logic [31:0] bx, input logic [31:0] by,
                                         input logic [31:0] bz);
        t_in_word w;
        w.req_type = kind;
        w.ax = ax;
        w.ay = ay;
        w.az = az;
        w.bx = bx;
        w.by = by;
        w.bz = bz;
        return w;
    endfunction

    function automatic t_in_word rand_word();
        logic [1:0] kind;
        kind = ($urandom_range(0, 99) < 3) ? REQ_UNUSED : 2'($urandom_range(0, 2));
        return mk_word(kind, rand_val(), rand_val(), rand_val(),
                       rand_val(), rand_val(), rand_val());
    endfunction

    task automatic set_coef(input int idx, input logic [31:0] even_c, input logic [31:0] odd_c);
        coef_wr_q.push_back({3'(idx), even_c, odd_c});
    endtask

    // Random matrix; the bottom row picks the flavour of w'.
    task automatic load_rand_matrix();
        int sel;
        sel = $urandom_range(0, 3);
        for (int i = 0; i < 6; i++)
            set_coef(i, rand_q16(sel == 3 ? 1 : 0), rand_q16(sel == 3 ? 1 : 0));
        case ($urandom_range(0, 3))
            0: begin
                set_coef(6, 32'd0, 32'd0);
                set_coef(7, 32'd0, Q_ONE);
            end
            1: begin
                set_coef(6, rand_q16(0), rand_q16(0));
                set_coef(7, rand_q16(0), rand_q16(0));
            end
            2: begin
                set_coef(6, 32'd0, 32'd0);
                set_coef(7, Q_ONE, 32'd0);  // w' = z
            end
            default: begin
                set_coef(6, $urandom(), $urandom());
                set_coef(7, $urandom(), $urandom());
            end
        endcase
    endtask

    // Wait for every write and word to land, then let the pipe run dry.
    task automatic drain();
        do @(negedge i_clk);
        while (coef_wr_q.size() > 0 || i_cfg_valid || cmd_q.size() > 0 || start
               || result_q.size() > 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic push_random(input int n);
        for (int i = 0; i < n; i++)
            cmd_q.push_back(rand_word());
    endtask

    initial begin
        fail_count = 0;
        gaps_on = 1'b1;
        start = 1'b0;
        i_in = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        for (int i = 0; i < NUM_REGS; i++)
            coef_bank[i] = coef_reset(i);
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Identity after reset: w' is exactly one, so no divide.
        cmd_q.push_back(mk_word(REQ_POINT, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0));
        cmd_q.push_back(mk_word(REQ_POINT, Q_MAX, Q_MAX, Q_MAX, 32'd0, 32'd0, 32'd0));
        cmd_q.push_back(mk_word(REQ_POINT, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX));
        cmd_q.push_back(mk_word(REQ_DIR, Q_MAX, Q_MIN, Q_ONE, Q_MAX, Q_MAX, Q_MAX));
        cmd_q.push_back(mk_word(REQ_BOX, Q_NEG_ONE, Q_NEG_ONE, Q_NEG_ONE, Q_ONE, Q_ONE, Q_ONE));
        // box given with min above max
        cmd_q.push_back(mk_word(REQ_BOX, Q_MAX, Q_ONE, 32'd5, Q_MIN, Q_NEG_ONE, 32'hFFFF_FFFB));
        cmd_q.push_back(mk_word(REQ_BOX, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX));
        cmd_q.push_back(mk_word(REQ_UNUSED, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        drain();

        // Projective: w' = z. Zero w, unit w, negative w, tiny w (quotient clamps).
        set_coef(0, Q_ONE, 32'h0000_8000);
        set_coef(1, 32'd0, 32'h0003_0000);
        set_coef(2, 32'hFFFF_8000, Q_ONE);
        set_coef(3, 32'd0, 32'h0000_0001);
        set_coef(4, 32'd0, 32'd0);
        set_coef(5, Q_ONE, 32'd0);
        set_coef(6, 32'd0, 32'd0);
        set_coef(7, Q_ONE, 32'd0);
        cmd_q.push_back(mk_word(REQ_POINT, Q_ONE, Q_ONE, 32'd0, 32'd0, 32'd0, 32'd0));
        cmd_q.push_back(mk_word(REQ_POINT, 32'h0002_0000, Q_ONE, Q_ONE, 32'd0, 32'd0, 32'd0));
        cmd_q.push_back(mk_word(REQ_POINT, 32'h0003_0000, Q_ONE, Q_NEG_ONE, 32'd0, 32'd0, 32'd0));
        cmd_q.push_back(mk_word(REQ_POINT, Q_MAX, Q_ONE, 32'd1, 32'd0, 32'd0, 32'd0));
        cmd_q.push_back(mk_word(REQ_POINT, Q_MIN, Q_MIN, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0));
        cmd_q.push_back(mk_word(REQ_POINT, 32'd3, 32'd0, 32'h0002_0000, 32'd0, 32'd0, 32'd0));
        cmd_q.push_back(mk_word(REQ_DIR, Q_MAX, Q_MAX, Q_MIN, 32'd0, 32'd0, 32'd0));
        cmd_q.push_back(mk_word(REQ_BOX, Q_NEG_ONE, Q_NEG_ONE, Q_NEG_ONE, Q_ONE, Q_ONE, Q_ONE));
        cmd_q.push_back(mk_word(REQ_BOX, 32'd0, 32'd0, Q_ONE, Q_ONE, Q_ONE, 32'h0002_0000));
        push_random(80);
        drain();

        // Saturating extremes across the whole matrix.
        for (int i = 0; i < NUM_REGS; i++)
            set_coef(i, Q_MAX, Q_MAX);
        push_random(80);
        drain();
        for (int i = 0; i < NUM_REGS; i++)
            set_coef(i, Q_MIN, Q_MIN);
        push_random(80);
        drain();

        // All-zero matrix: w' is always zero.
        for (int i = 0; i < NUM_REGS; i++)
            set_coef(i, 32'd0, 32'd0);
        push_random(40);
        drain();

        // Random matrices; every other phase runs back to back.
        for (int ph = 0; ph < 8; ph++) begin
            gaps_on = ph[0];
            load_rand_matrix();
            push_random(105);
            drain();
        end

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

[homogeneous_point_box_transform.f]
rtl/hpbt_pkg.sv
rtl/hpbt_mul.sv
rtl/hpbt_rsum.sv
rtl/hpbt_div.sv
rtl/hpbt_mm.sv
rtl/homogeneous_point_box_transform.sv
tb/sv/homogeneous_point_box_transform_test.sv
